>>> src/ocfp_pkg.sv
// Shared types and constants for the occupancy cell from pixel block.
// Used by the top level, the pipelined divider and the port checker.
package ocfp_pkg;

  localparam int QUANTUM_BITS_DEF = 16;
  localparam int MAX_SIDE_DEF     = 16384;

  localparam int QTY_W   = 16;
  localparam int COORD_W = 14;
  localparam int TH_W    = 16;
  localparam int SIDE_RW = 15;
  localparam int MODE_W  = 2;
  localparam int CELL_W  = 8;
  localparam int IDX_W   = 28;
  localparam int SUM_W   = QTY_W + 2;
  localparam int PRD_W   = SUM_W + TH_W;
  localparam int QUO_W   = 7;
  localparam int DVD_W   = PRD_W + QUO_W;
  localparam int DVS_W   = PRD_W;
  localparam int ADDR_W  = 5;
  localparam int APB_W   = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRINARY = 2'd0,
    MODE_SCALE   = 2'd1,
    MODE_RAW     = 2'd2
  } map_mode_t;

  localparam logic [2:0] REG_MAP_MODE  = 3'd0;
  localparam logic [2:0] REG_NEGATE    = 3'd1;
  localparam logic [2:0] REG_HAS_ALPHA = 3'd2;
  localparam logic [2:0] REG_FREE_TH   = 3'd3;
  localparam logic [2:0] REG_OCC_TH    = 3'd4;
  localparam logic [2:0] REG_WIDTH     = 3'd5;
  localparam logic [2:0] REG_HEIGHT    = 3'd6;

  localparam logic [TH_W-1:0] FREE_TH_RST = 16'd12780;
  localparam logic [TH_W-1:0] OCC_TH_RST  = 16'd42598;

  localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;
  localparam logic [CELL_W-1:0] CELL_FREE    = 8'd0;
  localparam logic [CELL_W-1:0] CELL_OCC     = 8'd100;

  localparam int PCT        = 100;
  localparam int RAW_SCALE2 = 510;
  localparam int RAW_LIM2   = 202;

  typedef struct packed {
    logic              use_div;
    logic              is_scale;
    logic [CELL_W-1:0] cell_val;
    logic [IDX_W-1:0]  idx;
  } cell_tag_t;

endpackage

>>> src/ocfp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ocfp_pkg for widths and the sideband tag type.
module ocfp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ocfp_pkg::DVD_W-1:0] in_dvd,
  input  logic [ocfp_pkg::DVS_W-1:0] in_dvs,
  input  ocfp_pkg::cell_tag_t        in_tag,
  output logic                       out_valid,
  output logic [ocfp_pkg::QUO_W-1:0] out_quo,
  output logic [ocfp_pkg::DVD_W-1:0] out_rem,
  output logic [ocfp_pkg::DVS_W-1:0] out_dvs,
  output ocfp_pkg::cell_tag_t        out_tag
);
  import ocfp_pkg::*;

  logic             stg_vld [QUO_W];
  logic [DVD_W-1:0] stg_rem [QUO_W];
  logic [QUO_W-1:0] stg_quo [QUO_W];
  logic [DVS_W-1:0] stg_dvs [QUO_W];
  cell_tag_t        stg_tag [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic             vin;
    logic [DVD_W-1:0] rin;
    logic [QUO_W-1:0] qin;
    logic [DVS_W-1:0] din;
    cell_tag_t        tin;
    logic [DVD_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign vin = in_valid;
      assign rin = in_dvd;
      assign qin = '0;
      assign din = in_dvs;
      assign tin = in_tag;
    end else begin : g_next
      assign vin = stg_vld[s-1];
      assign rin = stg_rem[s-1];
      assign qin = stg_quo[s-1];
      assign din = stg_dvs[s-1];
      assign tin = stg_tag[s-1];
    end

    assign trial = {1'b0, rin} - ((DVD_W+1)'(din) << B);
    assign ge    = ~trial[DVD_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_vld[s] <= 1'b0;
      end else if (en) begin
        stg_vld[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_rem[s] <= ge ? trial[DVD_W-1:0] : rin;
        stg_quo[s] <= qin | (QUO_W'(ge) << B);
        stg_dvs[s] <= din;
        stg_tag[s] <= tin;
      end
    end
  end

  assign out_valid = stg_vld[QUO_W-1];
  assign out_quo   = stg_quo[QUO_W-1];
  assign out_rem   = stg_rem[QUO_W-1];
  assign out_dvs   = stg_dvs[QUO_W-1];
  assign out_tag   = stg_tag[QUO_W-1];

endmodule

>>> src/occupancy_cell_from_pixel_top.sv
// Top level of the occupancy cell from pixel block: APB registers and the cell pipeline.
// Depends on ocfp_pkg and instantiates the pipelined divider ocfp_div.

// One pixel beat is accepted per clock unless the output stalls; its cell passes four
// stages of saturation, sums, threshold products and operand selection, seven stages
// of the divider that interpolates in scale mode and rounds in raw mode, and the
// rounding and output register. The whole pipeline holds while an output beat waits,
// so s_axis_tready follows m_axis_tready once the output register is full. Registers
// are to be written only while no pixel is in flight; the block does not enforce it.
module occupancy_cell_from_pixel_top #(
  parameter int QUANTUM_BITS = ocfp_pkg::QUANTUM_BITS_DEF,
  parameter int MAX_SIDE     = ocfp_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // red, green, blue, opacity (16 bits each), col, row (14 bits each), zero pad
  input  logic [95:0]                 s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // cell_res (8 bits, signed), cell_index (28 bits), zero pad
  output logic [39:0]                 m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ocfp_pkg::ADDR_W-1:0] paddr,
  input  logic [ocfp_pkg::APB_W-1:0]  pwdata,
  output logic [ocfp_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);
  import ocfp_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam logic [QTY_W-1:0] QMAX = QTY_W'((32'd1 << QUANTUM_BITS) - 32'd1);
  localparam logic [SUM_W-1:0] DEN3 = SUM_W'(3 * ((32'd1 << QUANTUM_BITS) - 32'd1));
  localparam logic [SUM_W-1:0] DEN4 = SUM_W'(4 * ((32'd1 << QUANTUM_BITS) - 32'd1));

  logic [MODE_W-1:0]  map_mode;
  logic               negate_shade;
  logic               has_alpha;
  logic [TH_W-1:0]    free_threshold;
  logic [TH_W-1:0]    occupied_threshold;
  logic [SIDE_RW-1:0] map_width;
  logic [SIDE_RW-1:0] map_height;

  logic en;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode           <= MODE_TRINARY;
      negate_shade       <= 1'b0;
      has_alpha          <= 1'b0;
      free_threshold     <= FREE_TH_RST;
      occupied_threshold <= OCC_TH_RST;
      map_width          <= SIDE_RW'(1);
      map_height         <= SIDE_RW'(1);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MAP_MODE:  map_mode           <= pwdata[MODE_W-1:0];
        REG_NEGATE:    negate_shade       <= pwdata[0];
        REG_HAS_ALPHA: has_alpha          <= pwdata[0];
        REG_FREE_TH:   free_threshold     <= pwdata[TH_W-1:0];
        REG_OCC_TH:    occupied_threshold <= pwdata[TH_W-1:0];
        REG_WIDTH:     map_width          <= pwdata[SIDE_RW-1:0];
        REG_HEIGHT:    map_height         <= pwdata[SIDE_RW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MAP_MODE:  prdata = APB_W'(map_mode);
      REG_NEGATE:    prdata = APB_W'(negate_shade);
      REG_HAS_ALPHA: prdata = APB_W'(has_alpha);
      REG_FREE_TH:   prdata = APB_W'(free_threshold);
      REG_OCC_TH:    prdata = APB_W'(occupied_threshold);
      REG_WIDTH:     prdata = APB_W'(map_width);
      REG_HEIGHT:    prdata = APB_W'(map_height);
      default:       prdata = '0;
    endcase
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: saturate the quanta, sum the channels and start the row flip.
  logic [QTY_W-1:0]  in_red, in_green, in_blue, in_op;
  logic [QTY_W-1:0]  r_sat, g_sat, b_sat, op_sat;
  logic [COORD_W-1:0] in_col, in_row;
  logic [SIDE_W-1:0] w_sat, h_sat;
  logic              alpha4;
  logic [SUM_W-1:0]  sum1;

  assign in_red   = s_axis_tdata[15:0];
  assign in_green = s_axis_tdata[31:16];
  assign in_blue  = s_axis_tdata[47:32];
  assign in_op    = s_axis_tdata[63:48];
  assign in_col   = s_axis_tdata[77:64];
  assign in_row   = s_axis_tdata[91:78];

  assign r_sat  = (in_red > QMAX) ? QMAX : in_red;
  assign g_sat  = (in_green > QMAX) ? QMAX : in_green;
  assign b_sat  = (in_blue > QMAX) ? QMAX : in_blue;
  assign op_sat = (in_op > QMAX) ? QMAX : in_op;

  assign w_sat = (32'(map_width) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(map_width);
  assign h_sat = (32'(map_height) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(map_height);

  assign alpha4 = (map_mode == MODE_TRINARY) && has_alpha;
  assign sum1   = SUM_W'(r_sat) + SUM_W'(g_sat) + SUM_W'(b_sat)
                + (alpha4 ? SUM_W'(QMAX - op_sat) : SUM_W'(0));

  logic               s1_vld;
  logic [SUM_W-1:0]   s1_sum;
  logic [SUM_W-1:0]   s1_den;
  logic               s1_opz;
  logic [IDX_W-1:0]   s1_rowd;
  logic [COORD_W-1:0] s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum  <= sum1;
      s1_den  <= alpha4 ? DEN4 : DEN3;
      s1_opz  <= (op_sat == '0);
      s1_rowd <= IDX_W'(h_sat) - IDX_W'(1) - IDX_W'(in_row);
      s1_col  <= in_col;
    end
  end

  // Stage 2: occupancy numerator and the threshold products.
  logic               s2_vld;
  logic [SUM_W-1:0]   s2_occ;
  logic [SUM_W-1:0]   s2_den;
  logic [PRD_W-1:0]   s2_hi;
  logic [PRD_W-1:0]   s2_lo;
  logic [PRD_W-1:0]   s2_span;
  logic               s2_thr_ok;
  logic [DVD_W-1:0]   s2_raw;
  logic [DVD_W-1:0]   s2_raw_lim;
  logic               s2_opz;
  logic [IDX_W-1:0]   s2_idx;
  logic [COORD_W-1:0] s2_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_occ     <= negate_shade ? s1_sum : s1_den - s1_sum;
      s2_den     <= s1_den;
      s2_hi      <= PRD_W'(occupied_threshold) * PRD_W'(s1_den);
      s2_lo      <= PRD_W'(free_threshold) * PRD_W'(s1_den);
      s2_span    <= PRD_W'(occupied_threshold - free_threshold) * PRD_W'(s1_den);
      s2_thr_ok  <= occupied_threshold > free_threshold;
      s2_raw     <= DVD_W'(s1_sum) * DVD_W'(RAW_SCALE2) + DVD_W'(s1_den);
      s2_raw_lim <= DVD_W'(s1_den) * DVD_W'(RAW_LIM2);
      s2_opz     <= s1_opz;
      s2_idx     <= IDX_W'(IDX_W'(w_sat) * s1_rowd);
      s2_col     <= s1_col;
    end
  end

  // Stage 3: threshold compares and the mode decision.
  logic [PRD_W-1:0] lhs3;
  logic             hit_occ, hit_free, raw_big;
  cell_tag_t        tag3;

  assign lhs3     = {s2_occ, {TH_W{1'b0}}};
  assign hit_occ  = s2_hi < lhs3;
  assign hit_free = lhs3 < s2_lo;
  assign raw_big  = s2_raw >= s2_raw_lim;

  always_comb begin
    tag3.use_div  = 1'b0;
    tag3.is_scale = 1'b0;
    tag3.cell_val = CELL_UNKNOWN;
    tag3.idx      = s2_idx + IDX_W'(s2_col);
    case (map_mode)
      MODE_TRINARY: begin
        if (hit_occ) begin
          tag3.cell_val = CELL_OCC;
        end else if (hit_free) begin
          tag3.cell_val = CELL_FREE;
        end
      end
      MODE_SCALE: begin
        if (!s2_opz) begin
          tag3.cell_val = CELL_UNKNOWN;
        end else if (hit_occ) begin
          tag3.cell_val = CELL_OCC;
        end else if (hit_free) begin
          tag3.cell_val = CELL_FREE;
        end else if (!s2_thr_ok) begin
          tag3.cell_val = CELL_FREE;
        end else begin
          tag3.use_div  = 1'b1;
          tag3.is_scale = 1'b1;
        end
      end
      MODE_RAW: begin
        if (!raw_big) begin
          tag3.use_div = 1'b1;
        end
      end
      default: tag3.cell_val = CELL_UNKNOWN;
    endcase
  end

  logic             s3_vld;
  logic [PRD_W-1:0] s3_num;
  logic [DVD_W-1:0] s3_raw;
  logic [DVS_W-1:0] s3_dvs;
  cell_tag_t        s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num <= lhs3 - s2_lo;
      s3_raw <= s2_raw;
      s3_dvs <= tag3.is_scale ? s2_span : DVS_W'({s2_den, 1'b0});
      s3_tag <= tag3;
    end
  end

  // Stage 4: dividend for the divider.
  logic             s4_vld;
  logic [DVD_W-1:0] s4_dvd;
  logic [DVS_W-1:0] s4_dvs;
  cell_tag_t        s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_dvd <= s3_tag.is_scale ? DVD_W'(s3_num) * DVD_W'(PCT) : s3_raw;
      s4_dvs <= s3_dvs;
      s4_tag <= s3_tag;
    end
  end

  logic             dv_vld;
  logic [QUO_W-1:0] dv_quo;
  logic [DVD_W-1:0] dv_rem;
  logic [DVS_W-1:0] dv_dvs;
  cell_tag_t        dv_tag;

  ocfp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_vld),
    .in_dvd    (s4_dvd),
    .in_dvs    (s4_dvs),
    .in_tag    (s4_tag),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_rem   (dv_rem),
    .out_dvs   (dv_dvs),
    .out_tag   (dv_tag)
  );

  // Output stage: round half to even in scale mode and clamp.
  logic [DVD_W:0]    rem2;
  logic              rnd_up;
  logic [QUO_W:0]    q_rnd;
  logic [CELL_W-1:0] cell_div;
  logic [CELL_W-1:0] cell_res;
  logic [IDX_W-1:0]  cell_index;

  assign rem2   = {dv_rem, 1'b0};
  assign rnd_up = dv_tag.is_scale
               && ((rem2 > (DVD_W+1)'(dv_dvs))
               || ((rem2 == (DVD_W+1)'(dv_dvs)) && dv_quo[0]));
  assign q_rnd    = (QUO_W+1)'(dv_quo) + (QUO_W+1)'(rnd_up);
  assign cell_div = (q_rnd > (QUO_W+1)'(PCT)) ? CELL_OCC : CELL_W'(q_rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_res   <= dv_tag.use_div ? cell_div : dv_tag.cell_val;
      cell_index <= dv_tag.idx;
    end
  end

  assign m_axis_tdata = {4'b0, cell_index, cell_res};

endmodule

>>> src/ocfp_chk.sv
// Port checker for the occupancy cell from pixel block, bound to the top level.
// Sees only the stream ports; depends on ocfp_pkg for the cell codes.
module ocfp_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import ocfp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == CELL_UNKNOWN) || (m_axis_tdata[7:0] <= CELL_OCC))
    else $error("cell value out of range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with free output");

endmodule

bind occupancy_cell_from_pixel_top ocfp_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
